### design/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg
// Types and constants shared by the running trapezoid integral block.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CNT_REG_W = 11;

  localparam logic CFG_UV_CUTOFF   = 1'b0;
  localparam logic CFG_TABLE_COUNT = 1'b1;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [15:0] UV_CUTOFF_RST   = 16'd2048;
  localparam logic [10:0] TABLE_COUNT_RST = 11'd2;

  // about 2^40 / (12 pi^2)
  localparam logic [33:0] RECIP    = 34'd9283651630;
  localparam logic [31:0] RECIP_LO = RECIP[31:0];
  localparam logic [31:0] RECIP_HI = {30'd0, RECIP[33:32]};

  localparam logic [63:0] SUM_MAX = {64{1'b1}};
  localparam logic [47:0] OUT_MAX = {48{1'b1}};

  typedef struct packed {
    logic        req_type;
    logic [9:0]  entry_index;
    logic [31:0] entry_key;
    logic [31:0] entry_power;
    logic [31:0] query_k;
    logic        last_query;
  } rti_in_t;

  typedef struct packed {
    logic [47:0] sigma_out;
    logic        below_table;
    logic        saturated;
  } rti_out_t;

  typedef enum logic [4:0] {
    S_IDLE, S_KMAX, S_CMP, S_RD0, S_RD1, S_EVAL, S_ACC, S_DIVI, S_DIV,
    S_PK, S_PART, S_END, S_SC0, S_SC1, S_SC2, S_SC3, S_SC4, S_OUT
  } rti_state_e;

  // Saturating 64-bit add, overflow flag in the top bit.
  function automatic logic [64:0] add_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[64]) begin
      return {1'b1, SUM_MAX};
    end
    return s;
  endfunction

endpackage

### design/running_trapezoid_integral.sv
// ----------------------------------------------------------------------------
// running_trapezoid_integral
// Table loader and running trapezoid integrator with a persistent walk.
// ----------------------------------------------------------------------------
//
//  channel   | signals                                  | beat
//  ----------+------------------------------------------+---------------------------
//  command   | start_i, busy_o, in_i                    | start_i & !busy_o
//  result    | result_valid_o, result_o                 | one cycle per strobe
//  config    | cfg_we_i, cfg_idx_i, cfg_data_i          | cfg_we_i, no wait
//
// A load beat never raises busy_o. After a query beat, busy_o stays high
// while the block scales the key and checks it against the first entry; a
// key below the table ends the query there. Otherwise the walk folds in
// every full segment up to the key or the table end, adds a partial segment
// when the key ends inside one (interpolated by the 32-step restoring divider
// when it lies strictly inside one) and scales the total. The result strobe
// comes in the cycle in which busy_o falls. Table reads go through one
// synchronous memory port, one entry per cycle.
// Reset clears the walk position, the running sum and the control state and
// restores the config defaults; the table itself is undefined until loaded.
// The receiver cannot stall results.
module running_trapezoid_integral #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  rti_pkg::rti_in_t     in_i,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [15:0]          cfg_data_i,
  output logic                 result_valid_o,
  output rti_pkg::rti_out_t    result_o
);
  import rti_pkg::*;

  localparam int unsigned AW    = $clog2(TABLE_DEPTH);
  localparam int unsigned CW0   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CNT_W = (CW0 > CNT_REG_W) ? CW0 : CNT_REG_W;
  localparam int unsigned MW    = 32 + VALUE_BITS;

  // Table memory: key in the upper word, power below.
  logic [MW-1:0] mem_q [TABLE_DEPTH];
  logic [MW-1:0] rdata_q;
  logic [AW-1:0] raddr;
  logic          mem_we;
  logic [AW-1:0] waddr;
  logic [AW+9:0] idx_ext;

  rti_state_e state_q, state_d;

  logic [15:0]      uv_cutoff_q;
  logic [10:0]      table_count_q;
  logic [CNT_W-1:0] cnt_ext, n_cnt, pos_ext;

  logic [AW-1:0] pos_q;
  logic [63:0]   sum_q;
  logic [31:0]   qk_q;
  logic          last_q;
  logic [35:0]   kmax_q;
  logic [31:0]   k0_q, p0_q, k1_q, p1_q;
  logic [31:0]   dx_q, dk_q;
  logic [31:0]   rem_q, dq_q;
  logic [4:0]    div_cnt_q;
  logic [63:0]   total_q;
  logic [97:0]   acc_q;
  logic          sat_q;
  logic          result_valid_q;
  rti_out_t      result_q;

  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] prod_q;

  // Combinational helpers
  logic [31:0] rd_key, rd_pow;
  logic [32:0] div_t;
  logic        div_ge;
  logic [31:0] dp;
  logic [31:0] pk;
  logic [64:0] seg_add;
  logic [64:0] part_add;

  assign rd_key = rdata_q[MW-1:VALUE_BITS];
  assign rd_pow = 32'(rdata_q[VALUE_BITS-1:0]);

  assign cnt_ext = CNT_W'(table_count_q);
  always_comb begin
    if (cnt_ext < CNT_W'(2)) begin
      n_cnt = CNT_W'(2);
    end else if (cnt_ext > CNT_W'(TABLE_DEPTH)) begin
      n_cnt = CNT_W'(TABLE_DEPTH);
    end else begin
      n_cnt = cnt_ext;
    end
  end
  assign pos_ext = CNT_W'(pos_q);

  assign dp     = (p1_q >= p0_q) ? (p1_q - p0_q) : (p0_q - p1_q);
  assign div_t  = {rem_q, dq_q[31]};
  assign div_ge = (div_t >= {1'b0, dk_q});
  assign pk     = (p1_q >= p0_q) ? (p0_q + dq_q) : (p0_q - dq_q);
  assign seg_add  = add_sat(sum_q, {15'd0, prod_q[64:16]});
  assign part_add = add_sat(sum_q, {15'd0, prod_q[64:16]});

  // Load address: ignore slots past the table.
  assign idx_ext = (AW + 10)'(in_i.entry_index);
  assign waddr   = idx_ext[AW-1:0];
  assign mem_we  = start_i && !busy_o && (in_i.req_type == REQ_LOAD) &&
                   ({22'd0, in_i.entry_index} < 32'(TABLE_DEPTH));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= {in_i.entry_key, in_i.entry_power[VALUE_BITS-1:0]};
    end
    rdata_q <= mem_q[raddr];
  end

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uv_cutoff_q   <= UV_CUTOFF_RST;
      table_count_q <= TABLE_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_UV_CUTOFF:   uv_cutoff_q   <= cfg_data_i;
        CFG_TABLE_COUNT: table_count_q <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i && in_i.req_type == REQ_QUERY) state_d = S_KMAX;
      end
      S_KMAX: state_d = S_CMP;
      S_CMP: begin
        if (prod_q[47:12] < {4'd0, rd_key}) begin
          state_d = S_IDLE;
        end else if (pos_ext + CNT_W'(1) >= n_cnt) begin
          state_d = S_END;
        end else begin
          state_d = S_RD0;
        end
      end
      S_RD0: state_d = S_RD1;
      S_RD1: state_d = S_EVAL;
      S_EVAL: begin
        if (kmax_q < {4'd0, k1_q}) begin
          state_d = (kmax_q > {4'd0, k0_q}) ? S_DIVI : S_PART;
        end else begin
          state_d = S_ACC;
        end
      end
      S_ACC:  state_d = (pos_ext + CNT_W'(2) < n_cnt) ? S_RD1 : S_END;
      S_DIVI: state_d = S_DIV;
      S_DIV:  state_d = (div_cnt_q == 5'd31) ? S_PK : S_DIV;
      S_PK:   state_d = S_PART;
      S_PART: state_d = S_SC0;
      S_END:  state_d = S_SC0;
      S_SC0:  state_d = S_SC1;
      S_SC1:  state_d = S_SC2;
      S_SC2:  state_d = S_SC3;
      S_SC3:  state_d = S_SC4;
      S_SC4:  state_d = S_OUT;
      S_OUT:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Memory address and multiplier operands
  always_comb begin
    raddr = pos_q;
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_KMAX: begin
        raddr = '0;
        mul_a = {1'b0, qk_q};
        mul_b = {16'd0, uv_cutoff_q};
      end
      S_CMP:  raddr = pos_q;
      S_RD0:  raddr = pos_q + AW'(1);
      S_EVAL: begin
        if (kmax_q < {4'd0, k1_q}) begin
          mul_a = {1'b0, kmax_q[31:0] - k0_q};
          mul_b = dp;
        end else begin
          mul_a = {1'b0, p0_q} + {1'b0, p1_q};
          mul_b = (k1_q > k0_q) ? (k1_q - k0_q) : 32'd0;
        end
      end
      S_ACC:  raddr = pos_q + AW'(2);
      S_PK: begin
        mul_a = {1'b0, pk} + {1'b0, p0_q};
        mul_b = dx_q;
      end
      S_SC0: begin
        mul_a = {1'b0, total_q[31:0]};
        mul_b = RECIP_LO;
      end
      S_SC1: begin
        mul_a = {1'b0, total_q[31:0]};
        mul_b = RECIP_HI;
      end
      S_SC2: begin
        mul_a = {1'b0, total_q[63:32]};
        mul_b = RECIP_LO;
      end
      S_SC3: begin
        mul_a = {1'b0, total_q[63:32]};
        mul_b = RECIP_HI;
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      pos_q          <= '0;
      sum_q          <= '0;
      result_valid_q <= 1'b0;
      div_cnt_q      <= '0;
    end else begin
      state_q        <= state_d;
      result_valid_q <= 1'b0;
      unique case (state_q)
        S_CMP: begin
          // Below the table: emit zero, leave the walk alone unless the query is last.
          if (prod_q[47:12] < {4'd0, rd_key}) begin
            result_valid_q <= 1'b1;
            if (last_q) begin
              pos_q <= '0;
              sum_q <= '0;
            end
          end
        end
        S_ACC: begin
          // Fold the full segment in and advance.
          sum_q <= seg_add[63:0];
          pos_q <= pos_q + AW'(1);
        end
        S_DIVI: div_cnt_q <= '0;
        S_DIV:  div_cnt_q <= div_cnt_q + 5'd1;
        S_OUT: begin
          result_valid_q <= 1'b1;
          if (last_q) begin
            pos_q <= '0;
            sum_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    unique case (state_q)
      S_IDLE: begin
        qk_q   <= in_i.query_k;
        last_q <= in_i.last_query;
        sat_q  <= 1'b0;
      end
      S_CMP: begin
        kmax_q <= prod_q[47:12];
        result_q.sigma_out   <= '0;
        result_q.below_table <= 1'b1;
        result_q.saturated   <= 1'b0;
      end
      S_RD0: ;
      S_RD1: begin
        k1_q <= rd_key;
        p1_q <= rd_pow;
      end
      S_EVAL: begin
        dx_q <= kmax_q[31:0] - k0_q;
        dk_q <= k1_q - k0_q;
      end
      S_ACC: begin
        if (seg_add[64]) sat_q <= 1'b1;
        k0_q <= k1_q;
        p0_q <= p1_q;
      end
      S_DIVI: begin
        rem_q <= prod_q[63:32];
        dq_q  <= prod_q[31:0];
      end
      S_DIV: begin
        rem_q <= div_ge ? 32'(div_t - {1'b0, dk_q}) : div_t[31:0];
        dq_q  <= {dq_q[30:0], div_ge};
      end
      S_PART: begin
        // Partial segment, zero when the key sits on the walk entry.
        if (kmax_q > {4'd0, k0_q}) begin
          total_q <= part_add[63:0];
          if (part_add[64] || sum_q == SUM_MAX) sat_q <= 1'b1;
        end else begin
          total_q <= sum_q;
          if (sum_q == SUM_MAX) sat_q <= 1'b1;
        end
      end
      S_END: begin
        total_q <= sum_q;
        if (sum_q == SUM_MAX) sat_q <= 1'b1;
      end
      S_SC1: acc_q <= {34'd0, prod_q[63:0]};
      S_SC2: acc_q <= acc_q + {2'd0, prod_q[63:0], 32'd0};
      S_SC3: acc_q <= acc_q + {2'd0, prod_q[63:0], 32'd0};
      S_SC4: acc_q <= acc_q + {prod_q[33:0], 64'd0};
      S_OUT: begin
        result_q.below_table <= 1'b0;
        if (acc_q[97:96] != 2'd0) begin
          result_q.sigma_out <= OUT_MAX;
          result_q.saturated <= 1'b1;
        end else begin
          result_q.sigma_out <= acc_q[95:48];
          result_q.saturated <= sat_q;
        end
      end
      default: ;
    endcase
    // The first walk entry is taken from the read register in S_RD0.
    if (state_q == S_RD0) begin
      k0_q <= rd_key;
      p0_q <= rd_pow;
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule

### verif/tb_running_trapezoid_integral.sv
// ----------------------------------------------------------------------------
// tb_running_trapezoid_integral
// Self-checking bench for the running trapezoid integral block: table loads
// and query beats go in through the command port, and an in-bench integrator
// predicts each query result. The run moves through several cutoff and table
// size settings, from a short directed part into random walks over mostly
// sorted tables.
// ----------------------------------------------------------------------------
module tb_running_trapezoid_integral;
  timeunit 1ns;
  timeprecision 1ps;

  import rti_pkg::*;

  localparam int unsigned DEPTH = 1024;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  rti_in_t     in_i;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        result_valid_o;
  rti_out_t    result_o;

  running_trapezoid_integral #(
    .TABLE_DEPTH(DEPTH),
    .VALUE_BITS (32)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .in_i          (in_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  // Beats waiting to be driven, and results the integrator still expects.
  rti_in_t  beat_q[$];
  rti_out_t sigma_q[$];

  int unsigned mismatches = 0;
  int unsigned beats_taken = 0;
  int unsigned items_queued = 0;
  bit          took_beat = 1'b0;

  // Integrator state: tables, walk position, running area and registers.
  logic [31:0] key_mem[DEPTH];
  logic [31:0] pwr_mem[DEPTH];
  logic [9:0]  walk_idx;
  logic [63:0] area_acc;
  logic [15:0] cutoff_q;
  logic [10:0] count_reg;

  // Generator's view of the table it loaded last and of the cutoff.
  logic [31:0] gen_key[DEPTH];
  int unsigned gen_n;
  logic [15:0] gen_cut;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #30ms;
    $display("Some tests failed");
    $finish;
  end

  // Twice a trapezoid area: (psum * d) >> 16, kept to 64 bits.
  function automatic logic [63:0] seg_area(logic [63:0] psum, logic [63:0] d);
    logic [127:0] pr;
    pr = {64'd0, psum} * {64'd0, d};
    return pr[79:16];
  endfunction

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b, ref bit ovf);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[64]) begin
      ovf = 1'b1;
      return SUM_MAX;
    end
    return s[63:0];
  endfunction

  // Work out one query result and advance the walk state.
  function automatic rti_out_t integrate_query(logic [31:0] qk, logic last);
    rti_out_t    r;
    logic [47:0] prod;
    logic [63:0] kmax, k0, k1, p0, p1, dx, dk, pk, partial, total;
    logic [127:0] sc;
    int unsigned n, pos;
    bit          ovf, done;
    ovf  = 1'b0;
    done = 1'b0;
    total = '0;
    r = '0;
    n = 32'(count_reg);
    if (n < 2) n = 2;
    if (n > DEPTH) n = DEPTH;
    prod = {16'd0, qk} * {32'd0, cutoff_q};
    kmax = {28'd0, prod[47:12]};
    if (kmax < {32'd0, key_mem[0]}) begin
      r.below_table = 1'b1;
    end else begin
      pos = 32'(walk_idx);
      while (pos < n - 1) begin
        k0 = 64'(key_mem[pos]);
        k1 = 64'(key_mem[pos + 1]);
        p0 = 64'(pwr_mem[pos]);
        p1 = 64'(pwr_mem[pos + 1]);
        if (kmax < k1) begin
          partial = '0;
          if (kmax > k0) begin
            dx = kmax - k0;
            dk = k1 - k0;
            if (p1 >= p0) pk = p0 + (dx * (p1 - p0)) / dk;
            else pk = p0 - (dx * (p0 - p1)) / dk;
            partial = seg_area(pk + p0, dx);
          end
          total = sat_add(area_acc, partial, ovf);
          done = 1'b1;
          break;
        end
        area_acc = sat_add(area_acc, seg_area(p0 + p1, (k1 > k0) ? k1 - k0 : 64'd0), ovf);
        pos++;
      end
      walk_idx = pos[9:0];
      if (!done) total = area_acc;
      if (area_acc == SUM_MAX) ovf = 1'b1;
      sc = {64'd0, total} * {94'd0, RECIP};
      if (|sc[127:96]) begin
        ovf = 1'b1;
        r.sigma_out = OUT_MAX;
      end else begin
        r.sigma_out = sc[95:48];
      end
      r.saturated = ovf;
    end
    if (last) begin
      walk_idx = '0;
      area_acc = '0;
    end
    return r;
  endfunction

  // Drive: present beats at the falling edge, with random idle bursts.
  always @(negedge clk_i) begin
    static int unsigned gap = 0;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (took_beat && beats_taken < 1500 && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 14);
      end
      took_beat = 1'b0;
      if (gap > 0) begin
        gap--;
        start_i <= 1'b0;
      end else if (beat_q.size() > 0) begin
        start_i <= 1'b1;
        in_i    <= beat_q[0];
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Sample at the rising edge: register writes, accepted beats, results.
  always @(posedge clk_i or negedge rst_ni) begin
    rti_out_t want;
    if (!rst_ni) begin
      walk_idx  = '0;
      area_acc  = '0;
      cutoff_q  = UV_CUTOFF_RST;
      count_reg = TABLE_COUNT_RST;
    end else begin
      if (result_valid_o) begin
        if (sigma_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat: %p", result_o);
        end else begin
          want = sigma_q.pop_front();
          if (result_o.sigma_out !== want.sigma_out ||
              result_o.below_table !== want.below_table ||
              result_o.saturated !== want.saturated) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch: sigma %h/%h below %b/%b sat %b/%b (exp/got)",
                       want.sigma_out, result_o.sigma_out, want.below_table,
                       result_o.below_table, want.saturated, result_o.saturated);
            end
          end
        end
      end
      if (start_i && !busy_o) begin
        if (in_i.req_type == REQ_LOAD) begin
          key_mem[in_i.entry_index] = in_i.entry_key;
          pwr_mem[in_i.entry_index] = in_i.entry_power;
        end else begin
          sigma_q.push_back(integrate_query(in_i.query_k, in_i.last_query));
        end
        void'(beat_q.pop_front());
        beats_taken++;
        took_beat = 1'b1;
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_UV_CUTOFF) cutoff_q = cfg_data_i;
        else count_reg = cfg_data_i[10:0];
      end
    end
  end

  task automatic push_load(logic [9:0] idx, logic [31:0] key, logic [31:0] pwr);
    rti_in_t b;
    b.req_type    = REQ_LOAD;
    b.entry_index = idx;
    b.entry_key   = key;
    b.entry_power = pwr;
    b.query_k     = $urandom;
    b.last_query  = 1'($urandom_range(0, 1));
    beat_q.push_back(b);
    items_queued++;
  endtask

  task automatic push_query(logic [31:0] qk, logic last);
    rti_in_t b;
    b.req_type    = REQ_QUERY;
    b.entry_index = 10'($urandom);
    b.entry_key   = $urandom;
    b.entry_power = $urandom;
    b.query_k     = qk;
    b.last_query  = last;
    beat_q.push_back(b);
    items_queued++;
  endtask

  // Hold until every beat is taken, every result is back and busy_o is low,
  // then wait on before touching the registers.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (beat_q.size() != 0 || sigma_q.size() != 0 || start_i || busy_o);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_data_i <= 16'($urandom);
  endtask

  // Load a table of n entries, keys mostly ascending with random steps.
  task automatic load_table(int unsigned n);
    logic [63:0] k, step;
    logic [31:0] p;
    k = $urandom_range(0, 3) == 0 ? 64'd0 : 64'($urandom_range(0, 32'h7FFF_FFFF));
    for (int unsigned i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: p = 32'hFFFF_FFFF;
        1: p = 32'd0;
        default: p = $urandom;
      endcase
      gen_key[i] = k[31:0];
      push_load(i[9:0], k[31:0], p);
      step = (64'hFFFF_FFFF - k) / (n - i);
      // equal neighbours and the odd backward step
      case ($urandom_range(0, 19))
        0: step = 0;
        1: k = k - (k >> 3);
        default: step = step == 0 ? 64'd0 : 64'($urandom_range(0, 32'(step)));
      endcase
      k = k + step;
    end
    gen_n = n;
    // drop a few loads outside the active table
    if (n < DEPTH) begin
      repeat ($urandom_range(0, 2)) begin
        push_load(10'($urandom_range(n, DEPTH - 1)), $urandom, $urandom);
      end
    end
  endtask

  // Runs of queries mostly at ascending scaled keys, each run closed by last.
  task automatic push_runs(int unsigned nq);
    logic [35:0]  tgt[$];
    logic [63:0]  q, lo_k, hi_k;
    int unsigned  run;
    while (nq > 0) begin
      run = $urandom_range(1, 6);
      if (run > nq) run = nq;
      nq -= run;
      tgt.delete();
      lo_k = 64'(gen_key[0]);
      hi_k = 64'(gen_key[gen_n - 1]);
      for (int unsigned i = 0; i < run; i++) begin
        case ($urandom_range(0, 9))
          0: tgt.push_back('1);
          1: tgt.push_back(lo_k == 0 ? 36'd0 : 36'($urandom_range(0, 32'(lo_k - 1))));
          2: tgt.push_back(36'(hi_k + $urandom_range(0, 255)));
          default: tgt.push_back(36'(lo_k + ((hi_k - lo_k) * $urandom_range(0, 1000)) / 1000));
        endcase
      end
      tgt.sort();
      for (int unsigned i = 0; i < run; i++) begin
        if (gen_cut == 0 || tgt[i] == '1 || $urandom_range(0, 15) == 0) begin
          q = 64'($urandom);
        end else begin
          q = ({28'd0, tgt[i]} << 12) / gen_cut;
          if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
        end
        push_query(q[31:0], i == run - 1);
      end
    end
  endtask

  initial begin
    int unsigned n;
    logic [15:0] cdata;
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    in_i       = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_UV_CUTOFF;
    cfg_data_i = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: one segment, falling power, below / on key / mid / end / past.
    write_reg(CFG_UV_CUTOFF, 16'd4096);
    write_reg(CFG_TABLE_COUNT, 16'd2);
    push_load(10'd0, 32'h0100_0000, 32'hFFFF_FFFF);
    push_load(10'd1, 32'h0300_0000, 32'd0);
    push_load(10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_query(32'd0, 1'b0);
    push_query(32'h0100_0000, 1'b0);
    push_query(32'h0200_0000, 1'b0);
    push_query(32'h0180_0000, 1'b0);
    push_query(32'h0300_0000, 1'b0);
    push_query(32'hFFFF_FFFF, 1'b1);
    wait_idle();

    // Largest cutoff, widest key span, count below range.
    write_reg(CFG_UV_CUTOFF, 16'hFFFF);
    write_reg(CFG_TABLE_COUNT, 16'd1);
    push_load(10'd0, 32'd0, 32'h0001_2345);
    push_load(10'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_query(32'h0000_1000, 1'b0);
    push_query(32'hFFFF_FFFF, 1'b1);
    push_query(32'h8000_0000, 1'b1);
    wait_idle();

    // Zero cutoff: every scaled key lands on zero.
    write_reg(CFG_UV_CUTOFF, 16'd0);
    push_query(32'hFFFF_FFFF, 1'b0);
    push_query(32'h1234_5678, 1'b1);
    wait_idle();

    // Full-depth table through a clamped count, walked by runs of queries.
    gen_cut = 16'd4096;
    write_reg(CFG_UV_CUTOFF, gen_cut);
    write_reg(CFG_TABLE_COUNT, 16'hFFFF);
    load_table(DEPTH);
    push_runs(12);
    wait_idle();

    // Random phases over small tables.
    while (items_queued < 1800) begin
      n = $urandom_range(0, 7) == 0 ? $urandom_range(2, 64) : $urandom_range(2, 12);
      case ($urandom_range(0, 7))
        0: gen_cut = 16'hFFFF;
        1: gen_cut = 16'd0;
        2: gen_cut = 16'd1;
        default: gen_cut = 16'($urandom);
      endcase
      cdata = n[15:0];
      if (n == 2 && $urandom_range(0, 1)) cdata = 16'($urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) cdata[15:11] = 5'($urandom);
      write_reg(CFG_UV_CUTOFF, gen_cut);
      write_reg(CFG_TABLE_COUNT, cdata);
      load_table(n);
      push_runs($urandom_range(8, 20));
      wait_idle();
    end

    do @(negedge clk_i);
    while (beat_q.size() != 0 || sigma_q.size() != 0);
    repeat (100) @(negedge clk_i);
    if (mismatches == 0 && sigma_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
